// File: hw/rtl/lct_pkg.sv
// Shared types, constants and helper functions of the link credit tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lct_pkg;

    // Width of the credit counter.
    localparam int COUNT_WIDTH = 32;

    // Largest exponent a single grant may carry.
    localparam int MAX_GRANT_EXP = 31;
    localparam int EXP_WIDTH     = 5;
    localparam int LEVEL_WIDTH   = 32;

    // An earned amount is at most 1 + 2^(15 - 3), which needs 13 bits.
    localparam int ADD_WIDTH = 13;
    localparam int SUM_WIDTH = ((COUNT_WIDTH > ADD_WIDTH) ? COUNT_WIDTH : ADD_WIDTH) + 1;

    localparam logic [2:0] ACK_DATA_OPCODE = 3'd1;
    localparam logic [2:0] CHAN_LOW        = 3'd1;
    localparam logic [2:0] CHAN_HIGH       = 3'd5;
    localparam logic [2:0] TRACKED_RESET   = 3'd4;
    localparam logic [3:0] SIZE_BASE       = 4'd3;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [1:0] {
        ACT_PKT_START = 2'd0,
        ACT_MSG_HDR   = 2'd1,
        ACT_PKT_END   = 2'd2,
        ACT_OUT_REQ   = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [2:0] msg_chan;
        logic [2:0] msg_opcode;
        logic [3:0] msg_size;
    } t_item;

    typedef struct packed {
        logic                   grant_valid;
        logic [EXP_WIDTH-1:0]   grant_exponent;
        logic [LEVEL_WIDTH-1:0] credit_level;
    } t_result;

    // Position of the highest set bit, capped at the largest grant exponent.
    // Returns zero for a zero count.
    function automatic logic [EXP_WIDTH-1:0] grant_exp(input t_count count);
        logic [EXP_WIDTH-1:0] e;
        e = '0;
        for (int i = 0; i < COUNT_WIDTH; i++) begin
            if (count[i]) begin
                e = (i >= MAX_GRANT_EXP) ? EXP_WIDTH'(MAX_GRANT_EXP) : EXP_WIDTH'(i);
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lct_in_reg.sv
// Input register of the link credit tracker: holds one accepted word.
// Depends on lct_pkg.
`default_nettype none

module lct_in_reg (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  lct_pkg::t_item i_item,
    input  wire          i_take,
    output logic         o_valid,
    output lct_pkg::t_item o_item
);
    import lct_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // The held word may be replaced in the same cycle it moves on.
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: hw/rtl/lct_credit_core.sv
// Credit counter, packet-start flag and tracked-channel register, with the
// earn and grant logic that updates them. Depends on lct_pkg.
`default_nettype none

module lct_credit_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire [2:0]      i_cfg_data,
    input  wire            i_fire,
    input  lct_pkg::t_item i_item,
    output lct_pkg::t_result o_result
);
    import lct_pkg::*;

    logic [2:0]           r_tracked;
    t_count               r_count;
    t_count               n_count;
    logic                 r_ack_owed;
    logic                 n_ack_owed;

    logic                 w_match;
    logic [ADD_WIDTH-1:0] w_bonus;
    logic [ADD_WIDTH-1:0] w_add;
    logic [SUM_WIDTH-1:0] w_sum;
    t_count               w_earned;
    logic [EXP_WIDTH-1:0] w_exp;
    t_count               w_granted;
    logic                 w_can_grant;
    logic                 w_grant;

    // Earn path: one credit per header, plus the data bonus on the tracked channel.
    assign w_match = (r_tracked >= CHAN_LOW) && (r_tracked <= CHAN_HIGH) &&
                     (i_item.msg_chan == r_tracked) &&
                     (i_item.msg_opcode == ACK_DATA_OPCODE);
    assign w_bonus = (i_item.msg_size >= SIZE_BASE)
                   ? (ADD_WIDTH'(1) << (i_item.msg_size - SIZE_BASE))
                   : ADD_WIDTH'(1);
    assign w_add    = w_match ? (w_bonus + ADD_WIDTH'(1)) : ADD_WIDTH'(1);
    assign w_sum    = SUM_WIDTH'(r_count) + SUM_WIDTH'(w_add);
    assign w_earned = (w_sum > SUM_WIDTH'({COUNT_WIDTH{1'b1}}))
                    ? {COUNT_WIDTH{1'b1}} : w_sum[COUNT_WIDTH-1:0];

    // Grant path: largest power of two not above the count.
    assign w_exp       = grant_exp(r_count);
    assign w_granted   = r_count - (t_count'(1) << w_exp);
    assign w_can_grant = (r_count != '0);

    always_comb begin
        n_count    = r_count;
        n_ack_owed = r_ack_owed;
        w_grant    = 1'b0;
        unique case (i_item.action)
            ACT_PKT_START: begin
                n_ack_owed = w_can_grant;
            end
            ACT_MSG_HDR: begin
                n_count = w_earned;
            end
            ACT_PKT_END: begin
                w_grant    = r_ack_owed && w_can_grant;
                n_ack_owed = 1'b0;
            end
            ACT_OUT_REQ: begin
                w_grant = w_can_grant;
            end
            default: begin
                w_grant = 1'b0;
            end
        endcase
        if (w_grant) begin
            n_count = w_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked  <= TRACKED_RESET;
            r_count    <= '0;
            r_ack_owed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tracked <= i_cfg_data;
            end
            if (i_fire) begin
                r_count    <= n_count;
                r_ack_owed <= n_ack_owed;
            end
        end
    end

    assign o_result.grant_valid    = w_grant;
    assign o_result.grant_exponent = w_grant ? w_exp : '0;
    assign o_result.credit_level   = LEVEL_WIDTH'(n_count);

endmodule

`default_nettype wire

// File: hw/rtl/lct_out_reg.sv
// Result register of the link credit tracker with its valid and stall.
// Depends on lct_pkg.
`default_nettype none

module lct_out_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  lct_pkg::t_result i_result,
    input  wire              i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output lct_pkg::t_result o_result
);
    import lct_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // A new result may enter when the register is empty or being drained.
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/link_credit_tracker.sv
// Top level of the link credit tracker: input register, credit core and result register.
// Depends on lct_pkg, lct_in_reg, lct_credit_core and lct_out_reg.
`default_nettype none

// The link credit tracker counts the receive credit owed to the link partner on
// one channel. Every received message header earns one credit; a data-carrying
// access acknowledge on the tracked channel earns 2^(size-3) more, or one more
// for sizes below 3, and the counter saturates at its top. A packet start notes
// whether credit is owed, and the matching packet end then grants the largest
// power of two not above the counter (at most 2^31); an outgoing-packet request
// always tries to grant. Every word returns exactly one result word carrying the
// grant flag, the grant exponent and the counter value after the word. The block
// takes one word per clock while the output is not stalled. The word is held in
// the input register, then the earn or grant logic (one priority encode and one
// add or subtract on the counter) writes the result register. The input register
// sits ahead of the result register and keeps accepting while a result waits as
// long as it is empty, so a stall on the output reaches the input one word later.
// The tracked channel register (1 = A through 5 = E, reset 4) is written through
// its own port, which is always ready, and should only be written while the
// block is idle.
module link_credit_tracker (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_data,

    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [2:0]  i_msg_chan,
    input  wire  [2:0]  i_msg_opcode,
    input  wire  [3:0]  i_msg_size,

    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_grant_valid,
    output logic [4:0]  o_grant_exponent,
    output logic [31:0] o_credit_level
);
    import lct_pkg::*;

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_out_ready;
    logic    w_fire;
    t_result w_core_result;
    t_result w_out_result;

    assign o_cfg_ready = 1'b1;

    assign w_in_item.action     = t_action'(i_action);
    assign w_in_item.msg_chan   = i_msg_chan;
    assign w_in_item.msg_opcode = i_msg_opcode;
    assign w_in_item.msg_size   = i_msg_size;

    // A held word is processed whenever the result register can take its result.
    assign w_fire = w_item_valid && w_out_ready;

    lct_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_take  (w_out_ready),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    lct_credit_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_item     (w_item),
        .o_result   (w_core_result)
    );

    lct_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_core_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_grant_valid    = w_out_result.grant_valid;
    assign o_grant_exponent = w_out_result.grant_exponent;
    assign o_credit_level   = w_out_result.credit_level;

    // The input only stalls when both registers are full and the output is held.
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && w_item_valid)
    ) else $error("input stalled while the pipeline had room");

    // A packet start never produces a grant.
    a_no_grant_on_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_item.action == ACT_PKT_START)) |-> !w_core_result.grant_valid
    ) else $error("grant issued on a packet start");

    // A drained result with nothing behind it leaves the result register empty.
    a_drain_empties: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_fire) |=> !o_out_valid
    ) else $error("result register still valid after drain");

    // The exponent reads zero on a result without a grant.
    a_exp_zero_without_grant: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_grant_valid) |-> (o_grant_exponent == '0)
    ) else $error("nonzero exponent without a grant");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for link_credit_tracker: random and directed words,
// one checked result per word.
// Depends on lct_pkg for the word and result types, the action codes and the counter width.
`timescale 1ns / 1ps

module testbench;
    import lct_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 100;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic [2:0]  i_cfg_data   = 3'd0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_action     = 2'd0;
    logic [2:0]  i_msg_chan   = 3'd0;
    logic [2:0]  i_msg_opcode = 3'd0;
    logic [3:0]  i_msg_size   = 4'd0;
    logic        i_out_stall  = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_grant_valid;
    logic [4:0]  o_grant_exponent;
    logic [31:0] o_credit_level;

    link_credit_tracker uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_msg_chan       (i_msg_chan),
        .i_msg_opcode     (i_msg_opcode),
        .i_msg_size       (i_msg_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_grant_valid    (o_grant_valid),
        .o_grant_exponent (o_grant_exponent),
        .o_credit_level   (o_credit_level)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Words waiting to be sent and results waiting to come back.
    t_item   pending_words[$];
    t_result expected_results[$];

    // Shadow copy of the block's state, updated as each word is accepted.
    t_count     credit_model = '0;
    bit         owed_model   = 1'b0;
    logic [2:0] chan_model   = TRACKED_RESET;

    // Last value written to the channel register, used to steer headers.
    logic [2:0] cfg_value = TRACKED_RESET;

    bit      idle_on    = 1'b1;
    bit      in_taken   = 1'b0;
    bit      out_taken  = 1'b0;
    int      send_gap   = 0;
    int      hold_gap   = 0;
    int      stuck_cycles = 0;
    int      failures   = 0;
    int      words_in   = 0;
    int      results_out = 0;
    int      cfg_writes = 0;
    t_item   next_word;
    t_item   seen_word;
    t_result want;

    // Most gaps are short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Grants the largest power of two not above the counter, at most 2^31.
    function automatic t_result grant_credit();
        t_result r;
        int      e;
        r = '0;
        if (credit_model != '0) begin
            e = MAX_GRANT_EXP;
            while (e > 0 && credit_model < (t_count'(1) << e)) e--;
            credit_model     = credit_model - (t_count'(1) << e);
            r.grant_valid    = 1'b1;
            r.grant_exponent = EXP_WIDTH'(e);
        end
        return r;
    endfunction

    function automatic t_result next_result(t_item w);
        t_result                r;
        logic [COUNT_WIDTH:0]   sum;
        logic [ADD_WIDTH-1:0]   bonus;
        r = '0;
        case (w.action)
            ACT_PKT_START: begin
                owed_model = (credit_model != '0);
            end
            ACT_MSG_HDR: begin
                bonus = ADD_WIDTH'(1);
                if (chan_model >= CHAN_LOW && chan_model <= CHAN_HIGH &&
                    w.msg_chan == chan_model && w.msg_opcode == ACK_DATA_OPCODE) begin
                    if (w.msg_size >= SIZE_BASE)
                        bonus = ADD_WIDTH'(1) + (ADD_WIDTH'(1) << (w.msg_size - SIZE_BASE));
                    else
                        bonus = ADD_WIDTH'(2);
                end
                // The counter saturates rather than wrapping.
                sum = {1'b0, credit_model} + (COUNT_WIDTH + 1)'(bonus);
                credit_model = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
            end
            ACT_PKT_END: begin
                if (owed_model) r = grant_credit();
                owed_model = 1'b0;
            end
            default: begin
                r = grant_credit();
            end
        endcase
        r.credit_level = credit_model[LEVEL_WIDTH-1:0];
        return r;
    endfunction

    function automatic t_item make_item(t_action a, logic [2:0] c, logic [2:0] op,
                                        logic [3:0] sz);
        t_item w;
        w.action     = a;
        w.msg_chan   = c;
        w.msg_opcode = op;
        w.msg_size   = sz;
        return w;
    endfunction

    function automatic t_item rand_item(t_action a);
        return make_item(a, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)));
    endfunction

    // Headers lean toward data acks on the tracked channel, with mostly small sizes.
    function automatic t_item rand_header();
        logic [2:0] c;
        logic [2:0] op;
        logic [3:0] sz;
        c  = ($urandom_range(0, 2) != 0) ? cfg_value : 3'($urandom_range(0, 7));
        op = ($urandom_range(0, 1) != 0) ? ACK_DATA_OPCODE : 3'($urandom_range(0, 7));
        sz = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 6));
        return make_item(ACT_MSG_HDR, c, op, sz);
    endfunction

    task automatic push_word(t_action a, logic [2:0] c, logic [2:0] op, logic [3:0] sz);
        pending_words.push_back(make_item(a, c, op, sz));
    endtask

    // Mostly well-formed packets (start, a few headers, end), mixed with grant requests and noise.
    task automatic queue_traffic(int n_words);
        int sent;
        int k;
        int r;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                pending_words.push_back(rand_item(ACT_PKT_START));
                k = $urandom_range(0, 5);
                repeat (k) pending_words.push_back(rand_header());
                pending_words.push_back(rand_item(ACT_PKT_END));
                sent += k + 2;
            end else if (r < 82) begin
                pending_words.push_back(rand_item(ACT_OUT_REQ));
                sent++;
            end else begin
                pending_words.push_back(rand_item(t_action'($urandom_range(0, 3))));
                sent++;
            end
        end
    endtask

    // Returns once every queued word went in and every result came back.
    // The check runs after the driver has settled its falling-edge updates.
    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0 || i_in_valid)
        begin
            @(negedge i_clk);
            #1;
        end
    endtask

    task automatic write_tracked(logic [2:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_value = v;
    endtask

    task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
        failures++;
        if (failures <= MAX_REPORTS)
            $error("%s mismatch on result %0d: expected %0d, got %0d",
                   field, results_out, exp_v, act_v);
    endtask

    // Input driver: holds a word until it is taken, then inserts an optional gap.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                next_word = pending_words.pop_front();
                i_action     <= next_word.action;
                i_msg_chan   <= next_word.msg_chan;
                i_msg_opcode <= next_word.msg_opcode;
                i_msg_size   <= next_word.msg_size;
                i_in_valid   <= 1'b1;
                send_gap = idle_on ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, in bursts of random length.
    always @(negedge i_clk) begin
        if (hold_gap > 0) begin
            hold_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 4) == 0) hold_gap = pick_gap();
        end
    end

    // Monitor: predicts on every accepted word, checks every accepted result.
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_taken = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (in_taken) begin
            seen_word = make_item(t_action'(i_action), i_msg_chan, i_msg_opcode, i_msg_size);
            expected_results.push_back(next_result(seen_word));
            words_in++;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready === 1'b1) begin
            chan_model = i_cfg_data;
            cfg_writes++;
        end
        if (out_taken) begin
            results_out++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $error("result %0d arrived with no word outstanding", results_out);
            end else begin
                want = expected_results.pop_front();
                if (o_grant_valid !== want.grant_valid)
                    note_mismatch("grant_valid", want.grant_valid, o_grant_valid);
                if (o_grant_exponent !== want.grant_exponent)
                    note_mismatch("grant_exponent", want.grant_exponent, o_grant_exponent);
                if (o_credit_level !== want.credit_level)
                    note_mismatch("credit_level", want.credit_level, o_credit_level);
            end
        end
        if (in_taken || out_taken || (i_cfg_valid && o_cfg_ready === 1'b1) ||
            (pending_words.size() == 0 && expected_results.size() == 0 &&
             !i_in_valid && !i_cfg_valid))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [2:0] settings[8];
        int         k;
        settings = '{3'd1, 3'd5, 3'd0, 3'd7, 3'd6, 3'd2, 3'd3, 3'd4};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed words with the channel register at its reset value.
        push_word(ACT_PKT_END,   3'd7, 3'd7, 4'd15);  // end with no start after reset
        push_word(ACT_OUT_REQ,   3'd0, 3'd0, 4'd0);   // grant request on an empty counter
        push_word(ACT_PKT_START, 3'd7, 3'd1, 4'd15);
        push_word(ACT_PKT_END,   3'd0, 3'd0, 4'd0);   // nothing was owed at the start
        push_word(ACT_MSG_HDR,   3'd4, ACK_DATA_OPCODE, 4'd0);
        push_word(ACT_MSG_HDR,   3'd4, ACK_DATA_OPCODE, 4'd2);
        push_word(ACT_MSG_HDR,   3'd4, ACK_DATA_OPCODE, 4'd3);
        push_word(ACT_MSG_HDR,   3'd4, ACK_DATA_OPCODE, 4'd15);
        push_word(ACT_MSG_HDR,   3'd4, 3'd0, 4'd15);  // wrong opcode earns one
        push_word(ACT_MSG_HDR,   3'd3, ACK_DATA_OPCODE, 4'd15);  // wrong channel
        push_word(ACT_MSG_HDR,   3'd7, 3'd7, 4'd15);
        push_word(ACT_MSG_HDR,   3'd0, 3'd0, 4'd0);
        push_word(ACT_PKT_START, 3'd7, 3'd7, 4'd15);
        push_word(ACT_PKT_END,   3'd7, 3'd7, 4'd15);  // owed, so it grants
        push_word(ACT_PKT_END,   3'd0, 3'd0, 4'd0);   // second end finds nothing owed
        push_word(ACT_PKT_START, 3'd0, 3'd0, 4'd0);
        push_word(ACT_OUT_REQ,   3'd7, 3'd7, 4'd15);  // must leave the owed flag alone
        push_word(ACT_PKT_END,   3'd0, 3'd0, 4'd0);
        push_word(ACT_OUT_REQ,   3'd0, 3'd0, 4'd0);
        push_word(ACT_OUT_REQ,   3'd0, 3'd0, 4'd0);
        push_word(ACT_MSG_HDR,   3'd4, ACK_DATA_OPCODE, 4'd4);
        wait_drained();

        // Random traffic under every channel setting, including the untracked ones.
        // Each phase boundary holds the sender until all results are back.
        for (k = 0; k < 8; k++) begin
            write_tracked(settings[k]);
            idle_on = (k % 3 != 2);
            queue_traffic(130);
            wait_drained();
        end

        // A full-rate burst of the largest data acks, then grants from a large count.
        write_tracked(3'd5);
        idle_on = 1'b0;
        repeat (40) push_word(ACT_MSG_HDR, 3'd5, ACK_DATA_OPCODE, 4'd15);
        wait_drained();
        idle_on = 1'b1;
        push_word(ACT_MSG_HDR,   3'd2, 3'd0, 4'd0);   // untracked channel earns one
        push_word(ACT_OUT_REQ,   3'd0, 3'd0, 4'd0);
        push_word(ACT_OUT_REQ,   3'd0, 3'd0, 4'd0);
        push_word(ACT_PKT_START, 3'd0, 3'd0, 4'd0);
        push_word(ACT_PKT_END,   3'd0, 3'd0, 4'd0);
        queue_traffic(150);
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d words and %0d results over %0d channel settings,",
                 words_in, results_out, cfg_writes);
        $display("with untracked channels, full-rate bursts and long output stalls.");
        if (failures == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
